>>> rtl/ftlfu_pkg.sv
// Package: payload structs, scan packet, write command and constants of the LFU table.
`default_nettype none
package ftlfu_pkg;

  localparam int CODE_W  = 21;
  localparam int WORD_W  = 16;
  localparam int SLOT_W  = 6;
  // widest entry index over the supported table sizes (up to 256 entries)
  localparam int IDX_MAX_W = 8;

  localparam logic [CODE_W-1:0] RANGE_LOW_RST  = 21'h004E00;
  localparam logic [CODE_W-1:0] RANGE_HIGH_RST = 21'h009FAF;
  localparam logic [WORD_W-1:0] SCORE_MAX      = 16'hFFFF;

  localparam logic OP_LEARN = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic CFG_RANGE_LOW  = 1'b0;
  localparam logic CFG_RANGE_HIGH = 1'b1;

  typedef struct packed {
    logic              opcode;
    logic [CODE_W-1:0] codepoint;
  } in_item_t;

  typedef struct packed {
    logic              accepted;
    logic              hit;
    logic [WORD_W-1:0] score;
    logic [SLOT_W-1:0] slot;
    logic [WORD_W-1:0] stamp;
  } out_item_t;

  // search packet that walks the cell row, one cell per cycle
  typedef struct packed {
    logic                 vld;
    logic                 opcode;
    logic [CODE_W-1:0]    code;
    logic                 hit;
    logic [IDX_MAX_W-1:0] hit_idx;
    logic [WORD_W-1:0]    hit_score;
    logic [WORD_W-1:0]    hit_stamp;
    logic                 empty;
    logic [IDX_MAX_W-1:0] empty_idx;
    logic [IDX_MAX_W-1:0] worst_idx;
    logic [WORD_W-1:0]    worst_score;
    logic [WORD_W-1:0]    worst_stamp;
  } scan_pkt_t;

  // entry update broadcast to the row
  typedef struct packed {
    logic                 en;
    logic [IDX_MAX_W-1:0] idx;
    logic [CODE_W-1:0]    code;
    logic [WORD_W-1:0]    score;
    logic [WORD_W-1:0]    stamp;
  } wr_cmd_t;

endpackage
`default_nettype wire

>>> rtl/ftlfu_cell.sv
// One table entry: holds the entry and updates the passing search packet.
`default_nettype none
module ftlfu_cell #(
  parameter int CELL_IDX = 0
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire ftlfu_pkg::scan_pkt_t pkt_in,
  input  wire ftlfu_pkg::wr_cmd_t   wr,
  output ftlfu_pkg::scan_pkt_t      pkt_out
);

  localparam logic [ftlfu_pkg::IDX_MAX_W-1:0] MY_IDX = ftlfu_pkg::IDX_MAX_W'(CELL_IDX);

  logic                         valid_r;
  logic [ftlfu_pkg::CODE_W-1:0] code_r;
  logic [ftlfu_pkg::WORD_W-1:0] score_r;
  logic [ftlfu_pkg::WORD_W-1:0] stamp_r;
  ftlfu_pkg::scan_pkt_t         pkt_r;
  ftlfu_pkg::scan_pkt_t         pkt_nxt;
  logic                         lower;

  always_comb begin
    lower = (score_r < pkt_in.worst_score) ||
            ((score_r == pkt_in.worst_score) && (stamp_r < pkt_in.worst_stamp));
    pkt_nxt = pkt_in;
    if (valid_r && !pkt_in.hit && (code_r == pkt_in.code)) begin
      pkt_nxt.hit       = 1'b1;
      pkt_nxt.hit_idx   = MY_IDX;
      pkt_nxt.hit_score = score_r;
      pkt_nxt.hit_stamp = stamp_r;
    end
    if (!valid_r && !pkt_in.empty) begin
      pkt_nxt.empty     = 1'b1;
      pkt_nxt.empty_idx = MY_IDX;
    end
    // first cell seeds the victim; later ones replace only on strictly lower
    if ((CELL_IDX == 0) || lower) begin
      pkt_nxt.worst_idx   = MY_IDX;
      pkt_nxt.worst_score = score_r;
      pkt_nxt.worst_stamp = stamp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pkt_r.vld <= 1'b0;
    end else begin
      pkt_r.vld <= pkt_in.vld;
    end
    pkt_r.opcode      <= pkt_nxt.opcode;
    pkt_r.code        <= pkt_nxt.code;
    pkt_r.hit         <= pkt_nxt.hit;
    pkt_r.hit_idx     <= pkt_nxt.hit_idx;
    pkt_r.hit_score   <= pkt_nxt.hit_score;
    pkt_r.hit_stamp   <= pkt_nxt.hit_stamp;
    pkt_r.empty       <= pkt_nxt.empty;
    pkt_r.empty_idx   <= pkt_nxt.empty_idx;
    pkt_r.worst_idx   <= pkt_nxt.worst_idx;
    pkt_r.worst_score <= pkt_nxt.worst_score;
    pkt_r.worst_stamp <= pkt_nxt.worst_stamp;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (wr.en && (wr.idx == MY_IDX)) begin
      valid_r <= 1'b1;
    end
    if (wr.en && (wr.idx == MY_IDX)) begin
      code_r  <= wr.code;
      score_r <= wr.score;
      stamp_r <= wr.stamp;
    end
  end

  assign pkt_out = pkt_r;

endmodule
`default_nettype wire

>>> rtl/frequency_table_lfu_replace.sv
// Top level: use-frequency table with least-used replacement over a row of entry cells.
// Path: the start beat is registered at the head, then by every cell, then as the result strobe.
// Flow: one item at a time, never a new one while busy; the search packet walks the
//   cell row one entry per cycle, and busy stays high until the result is issued.
// Reset: synchronous, active low; empties every entry, zeroes the stamp counter and
//   loads the range registers with 0x4E00 and 0x9FAF. The receiver cannot stall.
`default_nettype none
module frequency_table_lfu_replace #(
  parameter int TABLE_ENTRIES = 64
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                start,
  output logic                               busy,
  input  wire  ftlfu_pkg::in_item_t          in_data,
  output logic                               out_valid,
  output ftlfu_pkg::out_item_t               out_data,
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire                                cfg_index,
  input  wire  [ftlfu_pkg::CODE_W-1:0]       cfg_data
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  // config registers
  logic [ftlfu_pkg::CODE_W-1:0] range_low_r;
  logic [ftlfu_pkg::CODE_W-1:0] range_high_r;

  logic                         state_r;
  logic [ftlfu_pkg::WORD_W-1:0] stamp_cnt_r;
  ftlfu_pkg::scan_pkt_t         head_r;
  ftlfu_pkg::scan_pkt_t         chain [TABLE_ENTRIES+1];
  ftlfu_pkg::scan_pkt_t         tail;
  ftlfu_pkg::wr_cmd_t           wr;
  ftlfu_pkg::out_item_t         res_nxt;
  ftlfu_pkg::out_item_t         res_r;
  logic                         out_valid_r;
  logic                         in_accept;
  logic                         in_range;
  logic [ftlfu_pkg::WORD_W-1:0] stamp_nxt;
  logic [ftlfu_pkg::WORD_W-1:0] score_up;

  assign cfg_ready = 1'b1;
  assign busy      = (state_r == ST_SCAN);
  assign in_accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_low_r  <= ftlfu_pkg::RANGE_LOW_RST;
      range_high_r <= ftlfu_pkg::RANGE_HIGH_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ftlfu_pkg::CFG_RANGE_LOW:  range_low_r  <= cfg_data;
        ftlfu_pkg::CFG_RANGE_HIGH: range_high_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Load the search packet at the head of the row. Hit/empty flags start clear.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r.vld <= 1'b0;
    end else begin
      head_r.vld <= in_accept;
    end
    if (in_accept) begin
      head_r.opcode      <= in_data.opcode;
      head_r.code        <= in_data.codepoint;
      head_r.hit         <= 1'b0;
      head_r.hit_idx     <= '0;
      head_r.hit_score   <= '0;
      head_r.hit_stamp   <= '0;
      head_r.empty       <= 1'b0;
      head_r.empty_idx   <= '0;
      head_r.worst_idx   <= '0;
      head_r.worst_score <= '0;
      head_r.worst_stamp <= '0;
    end
  end

  assign chain[0] = head_r;

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    ftlfu_cell #(
      .CELL_IDX(g)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .pkt_in (chain[g]),
      .wr     (wr),
      .pkt_out(chain[g+1])
    );
  end

  assign tail = chain[TABLE_ENTRIES];

  // At the row end: a query reports any hit; an in-window learn updates, fills or replaces.
  always_comb begin
    in_range  = (tail.code >= range_low_r) && (tail.code <= range_high_r);
    stamp_nxt = stamp_cnt_r + ftlfu_pkg::WORD_W'(1);
    score_up  = (tail.hit_score == ftlfu_pkg::SCORE_MAX) ? ftlfu_pkg::SCORE_MAX
                                                         : tail.hit_score + ftlfu_pkg::WORD_W'(1);
    wr       = '0;
    res_nxt  = '0;
    if (tail.opcode == ftlfu_pkg::OP_QUERY) begin
      if (tail.hit) begin
        res_nxt.hit   = 1'b1;
        res_nxt.score = tail.hit_score;
        res_nxt.slot  = ftlfu_pkg::SLOT_W'(tail.hit_idx);
        res_nxt.stamp = tail.hit_stamp;
      end
    end else if (in_range) begin
      wr.en    = tail.vld;
      wr.code  = tail.code;
      wr.stamp = stamp_nxt;
      priority if (tail.hit) begin
        wr.idx   = tail.hit_idx;
        wr.score = score_up;
      end else if (tail.empty) begin
        wr.idx   = tail.empty_idx;
        wr.score = ftlfu_pkg::WORD_W'(1);
      end else begin
        wr.idx   = tail.worst_idx;
        wr.score = ftlfu_pkg::WORD_W'(1);
      end
      res_nxt.accepted = 1'b1;
      res_nxt.hit      = tail.hit;
      res_nxt.score    = wr.score;
      res_nxt.slot     = ftlfu_pkg::SLOT_W'(wr.idx);
      res_nxt.stamp    = stamp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      stamp_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= tail.vld;
      if (wr.en) begin
        stamp_cnt_r <= stamp_nxt;
      end
      unique case (state_r)
        ST_IDLE: if (in_accept) state_r <= ST_SCAN;
        ST_SCAN: if (tail.vld)  state_r <= ST_IDLE;
        default: state_r <= ST_IDLE;
      endcase
    end
    if (tail.vld) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = res_r;

  // one packet in flight: it only reaches the row end during a scan
  a_tail_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    tail.vld |-> (state_r == ST_SCAN))
    else $error("packet left the row outside a scan");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> busy && !out_valid)
    else $error("busy not raised after start beat");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_write_reports: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |=> out_valid && out_data.accepted && (out_data.stamp == stamp_cnt_r))
    else $error("entry write without matching accepted result");

  a_busy_clears: assert property (@(posedge clk) disable iff (!rst_n)
    tail.vld |=> !busy && out_valid)
    else $error("busy held after result");

endmodule
`default_nettype wire

>>> verif/frequency_table_lfu_replace_checker.sv
// Checker for the LFU table: tracks config writes and input beats, predicts each result, compares.
module frequency_table_lfu_replace_checker #(
  parameter int TABLE_ENTRIES = 64
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           start,
  input  wire                           busy,
  input  ftlfu_pkg::in_item_t           in_data,
  input  wire                           out_valid,
  input  ftlfu_pkg::out_item_t          out_data,
  input  wire                           cfg_valid,
  input  wire                           cfg_ready,
  input  wire                           cfg_index,
  input  wire [ftlfu_pkg::CODE_W-1:0]   cfg_data,
  output int                            mismatch_count,
  output int                            results_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow of the table
  logic [ftlfu_pkg::CODE_W-1:0] win_low;
  logic [ftlfu_pkg::CODE_W-1:0] win_high;
  logic                         used_q  [TABLE_ENTRIES];
  logic [ftlfu_pkg::CODE_W-1:0] code_q  [TABLE_ENTRIES];
  logic [ftlfu_pkg::WORD_W-1:0] score_q [TABLE_ENTRIES];
  logic [ftlfu_pkg::WORD_W-1:0] stamp_q [TABLE_ENTRIES];
  logic [ftlfu_pkg::WORD_W-1:0] stamp_now;

  ftlfu_pkg::out_item_t expected_results[$];
  int n_mismatch = 0;
  int n_waiting  = 0;

  assign mismatch_count = n_mismatch;
  assign results_owed   = n_waiting;

  // first empty entry, else least score, oldest stamp on a tie
  function automatic int pick_victim();
    int i;
    int worst;
    worst = 0;
    for (i = 0; i < TABLE_ENTRIES; i++) begin
      if (!used_q[i]) return i;
      if (score_q[i] < score_q[worst] ||
          (score_q[i] == score_q[worst] && stamp_q[i] < stamp_q[worst]))
        worst = i;
    end
    return worst;
  endfunction

  function automatic ftlfu_pkg::out_item_t learn_or_query(ftlfu_pkg::in_item_t item);
    ftlfu_pkg::out_item_t res;
    int                   at;
    int                   i;
    res = '0;
    at  = -1;
    for (i = 0; i < TABLE_ENTRIES; i++) begin
      if (at < 0 && used_q[i] && code_q[i] == item.codepoint) at = i;
    end
    if (item.opcode == ftlfu_pkg::OP_QUERY) begin
      if (at >= 0) begin
        res.hit   = 1'b1;
        res.score = score_q[at];
        res.slot  = at[ftlfu_pkg::SLOT_W-1:0];
        res.stamp = stamp_q[at];
      end
      return res;
    end
    // out of window (or inverted window): nothing changes
    if (item.codepoint < win_low || item.codepoint > win_high) return res;
    if (at < 0) begin
      at = pick_victim();
      used_q[at]  = 1'b1;
      code_q[at]  = item.codepoint;
      score_q[at] = ftlfu_pkg::WORD_W'(1);
    end else begin
      res.hit = 1'b1;
      if (score_q[at] != ftlfu_pkg::SCORE_MAX) score_q[at] = score_q[at] + 1'b1;
    end
    stamp_now   = stamp_now + 1'b1;
    stamp_q[at] = stamp_now;
    res.accepted = 1'b1;
    res.score    = score_q[at];
    res.slot     = at[ftlfu_pkg::SLOT_W-1:0];
    res.stamp    = stamp_q[at];
    return res;
  endfunction

  always @(posedge clk) begin
    ftlfu_pkg::out_item_t want;
    int i;
    if (!rst_n) begin
      win_low   = ftlfu_pkg::RANGE_LOW_RST;
      win_high  = ftlfu_pkg::RANGE_HIGH_RST;
      stamp_now = '0;
      for (i = 0; i < TABLE_ENTRIES; i++) begin
        used_q[i]  = 1'b0;
        code_q[i]  = '0;
        score_q[i] = '0;
        stamp_q[i] = '0;
      end
      expected_results.delete();
    end else begin
      // results first, so a beat taken at this edge never pairs with an older strobe
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("%t: result with none pending: acc %0d hit %0d score %0d slot %0d stamp %0d",
                     $realtime, out_data.accepted, out_data.hit, out_data.score,
                     out_data.slot, out_data.stamp);
        end else begin
          want = expected_results.pop_front();
          if (out_data.accepted !== want.accepted || out_data.hit !== want.hit ||
              out_data.score !== want.score || out_data.slot !== want.slot ||
              out_data.stamp !== want.stamp) begin
            n_mismatch++;
            if (n_mismatch <= 10)
              $display("%t: mismatch exp acc %0d hit %0d score %0d slot %0d stamp %0d,",
                       $realtime, want.accepted, want.hit, want.score, want.slot,
                       want.stamp,
                       " got acc %0d hit %0d score %0d slot %0d stamp %0d",
                       out_data.accepted, out_data.hit, out_data.score,
                       out_data.slot, out_data.stamp);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == ftlfu_pkg::CFG_RANGE_LOW) win_low = cfg_data;
        else win_high = cfg_data;
      end
      if (start && !busy) expected_results.push_back(learn_or_query(in_data));
    end
    n_waiting <= expected_results.size();
  end

endmodule

>>> verif/frequency_table_lfu_replace_tb.sv
// Testbench top: clock, reset, window programming and keystroke stimulus for the LFU table.
module frequency_table_lfu_replace_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ENTRIES     = 64;
  // one beat walks the whole cell row, plus issue and turnaround
  localparam int SCAN_CYCLES = ENTRIES + 2;

  // window settings the random phases step through
  typedef enum {WIN_CJK, WIN_NARROW, WIN_FULL, WIN_SINGLE, WIN_INVERTED} window_kind_t;

  logic                         clk       = 1'b0;
  logic                         rst_n     = 1'b0;
  logic                         start     = 1'b0;
  ftlfu_pkg::in_item_t          key_item  = '0;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_index = ftlfu_pkg::CFG_RANGE_LOW;
  logic [ftlfu_pkg::CODE_W-1:0] cfg_data  = '0;

  logic                 busy;
  logic                 out_valid;
  ftlfu_pkg::out_item_t out_data;
  logic                 cfg_ready;
  int                   mismatch_count;
  int                   results_owed;

  // window as last programmed; steers where random code points land
  logic [ftlfu_pkg::CODE_W-1:0] window_lo = ftlfu_pkg::RANGE_LOW_RST;
  logic [ftlfu_pkg::CODE_W-1:0] window_hi = ftlfu_pkg::RANGE_HIGH_RST;

  always #2 clk = ~clk;

  frequency_table_lfu_replace #(
    .TABLE_ENTRIES(ENTRIES)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (key_item),
    .out_valid(out_valid),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  frequency_table_lfu_replace_checker #(
    .TABLE_ENTRIES(ENTRIES)
  ) table_monitor (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_data       (key_item),
    .out_valid     (out_valid),
    .out_data      (out_data),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatch_count(mismatch_count),
    .results_owed  (results_owed)
  );

  // One beat on the input channel. start is left high on return so a
  // back-to-back beat never lowers and raises it in the same step.
  task automatic press_key(input logic op, input logic [ftlfu_pkg::CODE_W-1:0] cp);
    start    <= 1'b1;
    key_item <= {op, cp};
    do @(posedge clk); while (busy);
  endtask

  // Random idle burst. Half the bursts start once busy drops, so the gap is
  // actually seen by the block; the rest fall inside the scan.
  task automatic maybe_pause(input int pct);
    if ($urandom_range(0, 99) < pct) begin
      start <= 1'b0;
      if ($urandom_range(0, 1)) begin
        do @(posedge clk); while (busy);
      end
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  // Stop sending and wait until every predicted result has come back.
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
  endtask

  // Both window registers, valid held high across the two beats.
  task automatic set_code_window(input logic [ftlfu_pkg::CODE_W-1:0] lo,
                                 input logic [ftlfu_pkg::CODE_W-1:0] hi);
    cfg_valid <= 1'b1;
    cfg_index <= ftlfu_pkg::CFG_RANGE_LOW;
    cfg_data  <= lo;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= ftlfu_pkg::CFG_RANGE_HIGH;
    cfg_data  <= hi;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    window_lo = lo;
    window_hi = hi;
  endtask

  // Code point mix: a hot handful near the window base (builds score spread),
  // a warm pool of up to 151 codes (more than the table holds, so it evicts),
  // some fully random 21-bit noise, and the codes just outside the window.
  function automatic logic [ftlfu_pkg::CODE_W-1:0] pick_codepoint();
    int unsigned                  lo;
    int unsigned                  hi;
    int unsigned                  span;
    int unsigned                  r;
    logic [ftlfu_pkg::CODE_W-1:0] cp;
    lo   = 32'(window_lo);
    hi   = 32'(window_hi);
    span = (hi >= lo) ? ((hi - lo > 150) ? 150 : hi - lo) : 150;
    r    = $urandom_range(0, 99);
    if (r < 45)      cp = ftlfu_pkg::CODE_W'(lo + $urandom_range(0, (span < 7) ? span : 7));
    else if (r < 85) cp = ftlfu_pkg::CODE_W'(lo + $urandom_range(0, span));
    else if (r < 93) cp = ftlfu_pkg::CODE_W'($urandom_range(0, 32'h1FFFFF));
    else if (r[0])   cp = ftlfu_pkg::CODE_W'(lo - 1);
    else             cp = ftlfu_pkg::CODE_W'(hi + 1);
    return cp;
  endfunction

  initial begin
    window_kind_t plan [10];
    window_kind_t kind;
    logic [ftlfu_pkg::CODE_W-1:0] lo;
    logic [ftlfu_pkg::CODE_W-1:0] hi;
    int n_items;
    int idle_pct;
    int p;
    int k;

    plan = '{WIN_CJK, WIN_NARROW, WIN_FULL, WIN_NARROW, WIN_SINGLE,
             WIN_INVERTED, WIN_CJK, WIN_NARROW, WIN_FULL, WIN_NARROW};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // -- directed: reset window 0x4E00..0x9FAF --
    press_key(ftlfu_pkg::OP_QUERY, '0);                        // empty table, code zero
    press_key(ftlfu_pkg::OP_QUERY, '1);                        // all ones, miss
    press_key(ftlfu_pkg::OP_LEARN, ftlfu_pkg::RANGE_LOW_RST - 1);  // below window: rejected
    press_key(ftlfu_pkg::OP_LEARN, ftlfu_pkg::RANGE_HIGH_RST + 1); // above: rejected
    press_key(ftlfu_pkg::OP_LEARN, ftlfu_pkg::RANGE_LOW_RST);  // low edge: first empty entry
    press_key(ftlfu_pkg::OP_LEARN, ftlfu_pkg::RANGE_HIGH_RST); // high edge: next empty entry
    press_key(ftlfu_pkg::OP_LEARN, ftlfu_pkg::RANGE_LOW_RST);  // hit, score to 2
    press_key(ftlfu_pkg::OP_QUERY, ftlfu_pkg::RANGE_LOW_RST);  // query hit
    press_key(ftlfu_pkg::OP_LEARN, '1);                        // far out of window
    press_key(ftlfu_pkg::OP_LEARN, '0);                        // code zero, out of window
    settle();

    // -- directed: widest window, code zero is an ordinary code --
    set_code_window('0, '1);
    press_key(ftlfu_pkg::OP_LEARN, '0);
    press_key(ftlfu_pkg::OP_LEARN, '0);
    press_key(ftlfu_pkg::OP_QUERY, '0);
    press_key(ftlfu_pkg::OP_LEARN, '1);
    press_key(ftlfu_pkg::OP_QUERY, '1);
    settle();

    // -- directed: inverted window rejects every learn, queries still look up --
    set_code_window(21'h000100, 21'h000050);
    press_key(ftlfu_pkg::OP_LEARN, 21'h000060);
    press_key(ftlfu_pkg::OP_LEARN, 21'h000100);
    press_key(ftlfu_pkg::OP_QUERY, 21'h000060);
    press_key(ftlfu_pkg::OP_QUERY, '0);
    settle();

    // -- random phases, one window setting each; the table carries over --
    for (p = 0; p < 10; p++) begin
      kind = plan[p];
      case (kind)
        WIN_CJK: begin
          lo = ftlfu_pkg::RANGE_LOW_RST;
          hi = ftlfu_pkg::RANGE_HIGH_RST;
        end
        WIN_NARROW: begin
          lo = ftlfu_pkg::CODE_W'($urandom_range(0, 32'h1FFF00));
          hi = lo + ftlfu_pkg::CODE_W'($urandom_range(40, 200));
        end
        WIN_FULL: begin
          lo = '0;
          hi = '1;
        end
        WIN_SINGLE: begin
          lo = ftlfu_pkg::CODE_W'($urandom_range(0, 32'h1FFFFF));
          hi = lo;
        end
        default: begin
          lo = ftlfu_pkg::CODE_W'($urandom_range(1000, 32'h1FFFFF));
          hi = lo - ftlfu_pkg::CODE_W'($urandom_range(1, 500));
        end
      endcase
      set_code_window(lo, hi);

      // inverted window only feeds rejects, keep it short
      n_items = (kind == WIN_INVERTED) ? 40 : 220;
      // last phase runs flat out; others pick none, light or heavy idling
      if (p == 9) idle_pct = 0;
      else begin
        case ($urandom_range(0, 2))
          0:       idle_pct = 0;
          1:       idle_pct = 15;
          default: idle_pct = 50;
        endcase
      end

      for (k = 0; k < n_items; k++) begin
        press_key(($urandom_range(0, 3) == 0) ? ftlfu_pkg::OP_QUERY : ftlfu_pkg::OP_LEARN,
                  pick_codepoint());
        maybe_pause(idle_pct);
      end
      settle();
    end

    // catch any stray strobe after the last expected one
    repeat (SCAN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("frequency_table_lfu_replace_tb OK");
    end else begin
      $display("frequency_table_lfu_replace_tb NOT OK");
    end
    $finish;
  end

  // hard stop well past the slowest legal run (~2100 beats)
  initial begin
    #5_000_000;
    $display("frequency_table_lfu_replace_tb NOT OK");
    $finish;
  end

endmodule

>>> files.f
rtl/ftlfu_pkg.sv
rtl/ftlfu_cell.sv
rtl/frequency_table_lfu_replace.sv
verif/frequency_table_lfu_replace_checker.sv
verif/frequency_table_lfu_replace_tb.sv
